### src/edge_timed_uart_receiver_defines.svh
// Assertion macros for the edge-timed UART receiver.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef EDGE_TIMED_UART_RECEIVER_DEFINES_SVH
`define EDGE_TIMED_UART_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ERX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ERX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/erx_pkg.sv
// Shared types and constants of the edge-timed UART receiver.
// No dependencies; used by every module of the block except the generic queue.
`default_nettype none

package erx_pkg;

    localparam int LINES     = 4;
    localparam int LINE_W    = 2;
    localparam int CHAN_W    = 2;
    localparam int TIME_BITS = 32;
    localparam int TPB_W     = 16;
    localparam int THRESH_W  = 20;
    localparam int BITPOS_W  = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [BITPOS_W-1:0] STOP_DONE = 4'd10;
    localparam logic [BITPOS_W-1:0] DATA_BITS = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_ENABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT = 1'd1;

    localparam logic [LINES-1:0] RESET_LINE_ENABLE = 4'hF;
    localparam logic [TPB_W-1:0] RESET_TICKS       = 16'd104;

    typedef struct packed {
        logic [LINES-1:0]     levels;
        logic [LINES-1:0]     changed;
        logic [TIME_BITS-1:0] now;
        logic [LINES-1:0]     clr_ready;
        logic [LINES-1:0]     clr_framing;
        logic [LINES-1:0]     clr_overrun;
    } t_cmd;

    typedef struct packed {
        logic [CHAN_W-1:0] channel_index;
        logic [7:0]        data_byte;
        logic              framing_flag;
        logic              overrun_flag;
        logic [LINES-1:0]  ready_bits;
        logic              last_of_run;
    } t_result;

    typedef struct packed {
        logic busy;
        logic pend_valid;
    } t_back_status;

endpackage

`default_nettype wire

### src/erx_fifo.sv
// Small first-word-fall-through queue of register entries.
// Generic; width and depth come from parameters.
`default_nettype none

module erx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_full,
    input  wire logic             i_rd_en,
    output logic [WIDTH-1:0]      o_rd_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_ok, rd_ok;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_ok     = i_wr_en && !o_full;
    assign rd_ok     = i_rd_en && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_count = r_count + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

### src/erx_front.sv
// Front end: takes sample beats, tracks previous line levels, marks changed lines.
// Depends on erx_pkg for the command record.
`default_nettype none

module erx_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [erx_pkg::LINES-1:0]      i_line_enable,
    input  wire logic [erx_pkg::LINES-1:0]      i_line_levels,
    input  wire logic [erx_pkg::TIME_BITS-1:0]  i_now_ticks,
    input  wire logic [erx_pkg::LINES-1:0]      i_clear_ready_mask,
    input  wire logic [erx_pkg::LINES-1:0]      i_clear_framing_mask,
    input  wire logic [erx_pkg::LINES-1:0]      i_clear_overrun_mask,
    output erx_pkg::t_cmd                       o_cmd
);

    logic [erx_pkg::LINES-1:0] r_prev_levels;

    always_comb begin
        o_cmd.levels      = i_line_levels;
        o_cmd.changed     = (i_line_levels ^ r_prev_levels) & i_line_enable;
        o_cmd.now         = i_now_ticks;
        o_cmd.clr_ready   = i_clear_ready_mask;
        o_cmd.clr_framing = i_clear_framing_mask;
        o_cmd.clr_overrun = i_clear_overrun_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels <= '1;
        end else if (i_accept) begin
            r_prev_levels <= i_line_levels;
        end
    end

endmodule

`default_nettype wire

### src/erx_back.sv
// Back end: per-channel frame decoder, a bit period per cycle unless stalled.
// Depends on erx_pkg; reads commands from the front queue, writes results.
`default_nettype none

module erx_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [erx_pkg::LINES-1:0]     i_line_enable,
    input  wire logic [erx_pkg::TPB_W-1:0]     i_ticks_per_bit,
    input  wire erx_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_cmd_empty,
    output logic                               o_cmd_rd,
    input  wire logic                          i_res_full,
    output logic                               o_res_wr,
    output erx_pkg::t_result                   o_res_data,
    output erx_pkg::t_back_status              o_status
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_BITS   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_FLUSH  = 5'b10000
    } t_back_state;

    localparam int LN  = erx_pkg::LINES;
    localparam int TB  = erx_pkg::TIME_BITS;
    localparam int THW = erx_pkg::THRESH_W;
    localparam int BPW = erx_pkg::BITPOS_W;

    t_back_state                      r_state, n_state;
    erx_pkg::t_cmd                    r_cmd, n_cmd;
    logic [erx_pkg::LINE_W-1:0]       r_line, n_line;
    logic [erx_pkg::CHAN_W-1:0]       r_ch, n_ch;
    logic [TB-1:0]                    r_elapsed, n_elapsed;
    logic [THW-1:0]                   r_thresh, n_thresh;
    logic                             r_may_start, n_may_start;
    logic                             r_pend_valid, n_pend_valid;
    erx_pkg::t_result                 r_pend, n_pend;

    logic [TB-1:0]                    r_edge_time [LN];
    logic [TB-1:0]                    n_edge_time [LN];
    logic [7:0]                       r_shift     [LN];
    logic [7:0]                       n_shift     [LN];
    logic [BPW-1:0]                   r_bitpos    [LN];
    logic [BPW-1:0]                   n_bitpos    [LN];
    logic [LN-1:0]                    r_receiving, n_receiving;
    logic [LN-1:0]                    r_held, n_held;
    logic [LN-1:0]                    r_framing, n_framing;
    logic [LN-1:0]                    r_overrun, n_overrun;
    logic [LN-1:0]                    r_ready, n_ready;

    logic [erx_pkg::TPB_W-1:0]        tpb_eff;
    logic [erx_pkg::TPB_W-1:0]        half_up;
    logic                             last_line;
    logic                             step_due;
    logic [LN-1:0]                    ch_bit;

    assign tpb_eff   = (i_ticks_per_bit == '0) ? erx_pkg::TPB_W'(1) : i_ticks_per_bit;
    assign half_up   = tpb_eff - (tpb_eff >> 1);
    assign last_line = (r_line == erx_pkg::LINE_W'(LN - 1));
    assign ch_bit    = LN'(1) << r_ch;
    assign step_due  = (r_bitpos[r_ch] < erx_pkg::STOP_DONE) &&
                       (r_elapsed >= {{(TB - THW){1'b0}}, r_thresh});

    assign o_status.busy       = (r_state != ST_IDLE);
    assign o_status.pend_valid = r_pend_valid;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_line       = r_line;
        n_ch         = r_ch;
        n_elapsed    = r_elapsed;
        n_thresh     = r_thresh;
        n_may_start  = r_may_start;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_edge_time  = r_edge_time;
        n_shift      = r_shift;
        n_bitpos     = r_bitpos;
        n_receiving  = r_receiving;
        n_held       = r_held;
        n_framing    = r_framing;
        n_overrun    = r_overrun;
        n_ready      = r_ready;
        o_cmd_rd     = 1'b0;
        o_res_wr     = 1'b0;
        o_res_data   = r_pend;

        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_rd  = 1'b1;
                    n_cmd     = i_cmd;
                    n_ready   = r_ready & ~i_cmd.clr_ready;
                    n_framing = r_framing & ~i_cmd.clr_framing;
                    n_overrun = r_overrun & ~i_cmd.clr_overrun;
                    n_line    = '0;
                    n_ch      = '0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_line_enable[r_line] && r_cmd.changed[r_line]) begin
                    n_elapsed = r_cmd.now - r_edge_time[r_ch];
                    n_thresh  = THW'(half_up);
                    if (r_receiving[r_ch]) begin
                        n_may_start = 1'b0;
                        n_state     = ST_BITS;
                    end else begin
                        n_may_start = 1'b1;
                        n_state     = ST_FINISH;
                    end
                end else begin
                    if (i_line_enable[r_line]) begin
                        n_ch = r_ch + 1'b1;
                    end
                    if (last_line) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_line = r_line + 1'b1;
                    end
                end
            end
            ST_BITS: begin
                if (step_due) begin
                    if (r_bitpos[r_ch] == '0) begin
                        n_bitpos[r_ch] = BPW'(1);
                        n_thresh       = r_thresh + THW'(tpb_eff);
                    end else if (r_bitpos[r_ch] <= erx_pkg::DATA_BITS) begin
                        n_shift[r_ch]  = {r_held[r_ch], r_shift[r_ch][7:1]};
                        n_bitpos[r_ch] = r_bitpos[r_ch] + 1'b1;
                        n_thresh       = r_thresh + THW'(tpb_eff);
                    end else if (!(r_pend_valid && i_res_full)) begin
                        // stop bit: park the beat until the run's end is known
                        if (r_pend_valid) begin
                            o_res_wr = 1'b1;
                        end
                        n_framing[r_ch]      = r_framing[r_ch] | ~r_held[r_ch];
                        n_overrun[r_ch]      = r_overrun[r_ch] | r_ready[r_ch];
                        n_ready              = r_ready | ch_bit;
                        n_bitpos[r_ch]       = erx_pkg::STOP_DONE;
                        n_thresh             = r_thresh + THW'(tpb_eff);
                        n_pend_valid         = 1'b1;
                        n_pend.channel_index = r_ch;
                        n_pend.data_byte     = r_shift[r_ch];
                        n_pend.framing_flag  = r_framing[r_ch] | ~r_held[r_ch];
                        n_pend.overrun_flag  = r_overrun[r_ch] | r_ready[r_ch];
                        n_pend.ready_bits    = r_ready | ch_bit;
                        n_pend.last_of_run   = 1'b0;
                    end
                end else begin
                    if (r_bitpos[r_ch] >= erx_pkg::STOP_DONE) begin
                        n_receiving[r_ch] = 1'b0;
                        n_may_start       = 1'b1;
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (r_may_start && r_held[r_ch] && !r_cmd.levels[r_line]) begin
                    n_receiving[r_ch] = 1'b1;
                    n_bitpos[r_ch]    = '0;
                    n_shift[r_ch]     = '0;
                end
                n_held[r_ch]      = r_cmd.levels[r_line];
                n_edge_time[r_ch] = r_cmd.now;
                n_ch              = r_ch + 1'b1;
                if (last_line) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_line  = r_line + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_FLUSH: begin
                o_res_data.last_of_run = 1'b1;
                if (r_pend_valid) begin
                    if (!i_res_full) begin
                        o_res_wr     = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_receiving  <= '0;
            r_held       <= '1;
            r_framing    <= '0;
            r_overrun    <= '0;
            r_ready      <= '0;
            for (int i = 0; i < LN; i++) begin
                r_edge_time[i] <= '0;
                r_shift[i]     <= '0;
                r_bitpos[i]    <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_receiving  <= n_receiving;
            r_held       <= n_held;
            r_framing    <= n_framing;
            r_overrun    <= n_overrun;
            r_ready      <= n_ready;
            r_edge_time  <= n_edge_time;
            r_shift      <= n_shift;
            r_bitpos     <= n_bitpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_line      <= n_line;
        r_ch        <= n_ch;
        r_elapsed   <= n_elapsed;
        r_thresh    <= n_thresh;
        r_may_start <= n_may_start;
        r_pend      <= n_pend;
    end

endmodule

`default_nettype wire

### src/edge_timed_uart_receiver.sv
// Sample beats enter a command queue; full rises only when it holds CMD_DEPTH.
// The decoder reads each sample, scans its lines and flushes; per decoded line edge it updates
// the line, enters and leaves the bit steps, and makes one compare-and-add of the bit
// threshold per counted bit period (at most 10 per edge). A completed byte waits while the
// result queue is full; a beat written to an empty result queue is on the outputs next cycle.
// Synchronous active-low reset: enable mask 0xF, 104 ticks per bit, lines idle high,
// all channels idle with clear flags, both queues empty.
`default_nettype none

`include "edge_timed_uart_receiver_defines.svh"

module edge_timed_uart_receiver #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [erx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [erx_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [erx_pkg::LINES-1:0]        i_line_levels,
    input  wire logic [erx_pkg::TIME_BITS-1:0]    i_now_ticks,
    input  wire logic [erx_pkg::LINES-1:0]        i_clear_ready_mask,
    input  wire logic [erx_pkg::LINES-1:0]        i_clear_framing_mask,
    input  wire logic [erx_pkg::LINES-1:0]        i_clear_overrun_mask,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [erx_pkg::CHAN_W-1:0]            o_channel_index,
    output logic [7:0]                            o_data_byte,
    output logic                                  o_framing_flag,
    output logic                                  o_overrun_flag,
    output logic [erx_pkg::LINES-1:0]             o_ready_bits,
    output logic                                  o_last_of_run
);

    logic [erx_pkg::LINES-1:0]  r_line_enable;
    logic [erx_pkg::TPB_W-1:0]  r_ticks_per_bit;

    logic                       w_accept;
    erx_pkg::t_cmd              w_front_cmd;
    erx_pkg::t_cmd              w_cmd;
    logic                       w_cmd_empty;
    logic                       w_cmd_rd;
    logic                       w_res_full;
    logic                       w_res_wr;
    erx_pkg::t_result           w_res_in;
    erx_pkg::t_result           w_res_out;
    erx_pkg::t_back_status      w_status;

    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_enable   <= erx_pkg::RESET_LINE_ENABLE;
            r_ticks_per_bit <= erx_pkg::RESET_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                erx_pkg::REG_LINE_ENABLE: begin
                    r_line_enable <= i_cfg_data[erx_pkg::LINES-1:0];
                end
                erx_pkg::REG_TICKS_PER_BIT: begin
                    r_ticks_per_bit <= i_cfg_data[erx_pkg::TPB_W-1:0];
                end
                default: begin
                    r_line_enable <= r_line_enable;
                end
            endcase
        end
    end

    erx_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (w_accept),
        .i_line_enable        (r_line_enable),
        .i_line_levels        (i_line_levels),
        .i_now_ticks          (i_now_ticks),
        .i_clear_ready_mask   (i_clear_ready_mask),
        .i_clear_framing_mask (i_clear_framing_mask),
        .i_clear_overrun_mask (i_clear_overrun_mask),
        .o_cmd                (w_front_cmd)
    );

    erx_fifo #(
        .WIDTH ($bits(erx_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push),
        .i_wr_data (w_front_cmd),
        .o_full    (full),
        .i_rd_en   (w_cmd_rd),
        .o_rd_data (w_cmd),
        .o_empty   (w_cmd_empty)
    );

    erx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_enable   (r_line_enable),
        .i_ticks_per_bit (r_ticks_per_bit),
        .i_cmd           (w_cmd),
        .i_cmd_empty     (w_cmd_empty),
        .o_cmd_rd        (w_cmd_rd),
        .i_res_full      (w_res_full),
        .o_res_wr        (w_res_wr),
        .o_res_data      (w_res_in),
        .o_status        (w_status)
    );

    erx_fifo #(
        .WIDTH ($bits(erx_pkg::t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_res_wr),
        .i_wr_data (w_res_in),
        .o_full    (w_res_full),
        .i_rd_en   (pop),
        .o_rd_data (w_res_out),
        .o_empty   (empty)
    );

    assign o_channel_index = w_res_out.channel_index;
    assign o_data_byte     = w_res_out.data_byte;
    assign o_framing_flag  = w_res_out.framing_flag;
    assign o_overrun_flag  = w_res_out.overrun_flag;
    assign o_ready_bits    = w_res_out.ready_bits;
    assign o_last_of_run   = w_res_out.last_of_run;

    `ERX_ASSERT_NOW(a_res_no_overflow, w_res_wr, !w_res_full, "result beat written into full queue")
    `ERX_ASSERT_NOW(a_cmd_no_underflow, w_cmd_rd, !w_cmd_empty, "command read from empty queue")
    `ERX_ASSERT_NOW(a_pend_only_busy, !w_status.busy, !w_status.pend_valid, "parked beat left at idle")
    `ERX_ASSERT_NEXT(a_rd_starts_decode, w_cmd_rd, w_status.busy, "decoder idle after command read")

endmodule

`default_nettype wire

### tb/edge_timed_uart_receiver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for edge_timed_uart_receiver: drives 8N1 frames as edge samples,
// predicts every decoded byte and checks each result beat in order.
// Depends on erx_pkg and the edge_timed_uart_receiver top level.

module edge_timed_uart_receiver_tb;

    localparam int LINES     = erx_pkg::LINES;
    localparam int TIME_BITS = erx_pkg::TIME_BITS;
    localparam int TPB_W     = erx_pkg::TPB_W;
    localparam int BITPOS_W  = erx_pkg::BITPOS_W;
    localparam int CHAN_W    = erx_pkg::CHAN_W;
    localparam int CFG_W     = erx_pkg::CFG_W;
    localparam int CFG_IDX_W = erx_pkg::CFG_IDX_W;

    localparam logic [BITPOS_W-1:0]  STOP_DONE         = erx_pkg::STOP_DONE;
    localparam logic [BITPOS_W-1:0]  DATA_BITS         = erx_pkg::DATA_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_ENABLE   = erx_pkg::REG_LINE_ENABLE;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT = erx_pkg::REG_TICKS_PER_BIT;
    localparam logic [LINES-1:0]     RESET_LINE_ENABLE = erx_pkg::RESET_LINE_ENABLE;
    localparam logic [TPB_W-1:0]     RESET_TICKS       = erx_pkg::RESET_TICKS;

    typedef erx_pkg::t_result t_result;

    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASES         = 6;

    localparam logic [LINES-1:0] PHASE_MASK [PHASES] = '{4'hF, 4'h5, 4'hF, 4'hA, 4'h0, 4'h8};
    localparam logic [TPB_W-1:0] PHASE_TICKS [PHASES] =
        '{16'd104, 16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd0};
    localparam int PHASE_ITEMS [PHASES] = '{60, 40, 30, 30, 10, 40};
    localparam int PHASE_SEND_IDLE [PHASES] = '{31, 87, 87, 0, 0, 0};
    localparam int PHASE_RECV_IDLE [PHASES] = '{87, 31, 31, 0, 0, 0};

    class rx_byte_scoreboard;
        logic [LINES-1:0]     line_enable;
        logic [TPB_W-1:0]     tick_period;
        logic [LINES-1:0]     last_levels;
        logic [TIME_BITS-1:0] edge_stamp [LINES];
        logic [7:0]           shifter [LINES];
        bit                   in_frame [LINES];
        bit                   level_held [LINES];
        logic [BITPOS_W-1:0]  bit_pos [LINES];
        bit                   framing_err [LINES];
        bit                   overrun_err [LINES];
        logic [LINES-1:0]     ready;
        t_result              due_bytes [$];
        int                   errors;
        int                   samples;
        int                   bytes_seen;
        int                   framing_seen;
        int                   overrun_seen;

        function new();
            line_enable = RESET_LINE_ENABLE;
            tick_period = RESET_TICKS;
            last_levels = '1;
            ready = '0;
            for (int i = 0; i < LINES; i++) begin
                edge_stamp[i] = '0;
                shifter[i] = '0;
                in_frame[i] = 1'b0;
                level_held[i] = 1'b1;
                bit_pos[i] = '0;
                framing_err[i] = 1'b0;
                overrun_err[i] = 1'b0;
            end
            errors = 0;
            samples = 0;
            bytes_seen = 0;
            framing_seen = 0;
            overrun_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_LINE_ENABLE) begin
                line_enable = data[LINES-1:0];
            end else begin
                tick_period = data[TPB_W-1:0];
            end
        endfunction

        // Decode one sample beat and queue the bytes it completes, in channel order.
        function void note_sample(logic [LINES-1:0] levels, logic [TIME_BITS-1:0] now,
                                  logic [LINES-1:0] clr_rdy, logic [LINES-1:0] clr_frm,
                                  logic [LINES-1:0] clr_ovr);
            logic [LINES-1:0]     changed;
            logic [TIME_BITS-1:0] period;
            logic [TIME_BITS-1:0] elapsed;
            logic [TIME_BITS:0]   bits_due;
            t_result              res;
            int                   ch;
            int                   first;
            bit                   start_ok;
            bit                   lvl;
            ch = 0;
            first = due_bytes.size();
            period = (tick_period == '0) ? 32'd1 : {16'd0, tick_period};
            samples++;
            for (int i = 0; i < LINES; i++) begin
                if (clr_rdy[i]) ready[i] = 1'b0;
                if (clr_frm[i]) framing_err[i] = 1'b0;
                if (clr_ovr[i]) overrun_err[i] = 1'b0;
            end
            changed = (levels ^ last_levels) & line_enable;
            last_levels = levels;
            for (int ln = 0; ln < LINES; ln++) begin
                if (line_enable[ln]) begin
                    if (changed[ln]) begin
                        lvl = levels[ln];
                        elapsed = now - edge_stamp[ch];
                        bits_due = elapsed / period;
                        if (elapsed % period >= period - period / 2) bits_due = bits_due + 1;
                        if (bits_due > STOP_DONE) bits_due = (TIME_BITS + 1)'(STOP_DONE);
                        start_ok = !in_frame[ch];
                        if (in_frame[ch]) begin
                            while (bits_due != 0 && bit_pos[ch] < STOP_DONE) begin
                                bits_due = bits_due - 1;
                                if (bit_pos[ch] == '0) begin
                                    bit_pos[ch] = 4'd1;
                                end else if (bit_pos[ch] <= DATA_BITS) begin
                                    shifter[ch] = {level_held[ch], shifter[ch][7:1]};
                                    bit_pos[ch] = bit_pos[ch] + 4'd1;
                                end else begin
                                    if (!level_held[ch]) framing_err[ch] = 1'b1;
                                    if (ready[ch]) overrun_err[ch] = 1'b1;
                                    ready[ch] = 1'b1;
                                    bit_pos[ch] = STOP_DONE;
                                    res.channel_index = CHAN_W'(ch);
                                    res.data_byte = shifter[ch];
                                    res.framing_flag = framing_err[ch];
                                    res.overrun_flag = overrun_err[ch];
                                    res.ready_bits = ready;
                                    res.last_of_run = 1'b0;
                                    due_bytes.push_back(res);
                                end
                            end
                            if (bit_pos[ch] >= STOP_DONE) begin
                                in_frame[ch] = 1'b0;
                                start_ok = 1'b1;
                            end
                        end
                        if (start_ok && level_held[ch] && !lvl) begin
                            in_frame[ch] = 1'b1;
                            bit_pos[ch] = '0;
                            shifter[ch] = '0;
                        end
                        level_held[ch] = lvl;
                        edge_stamp[ch] = now;
                    end
                    ch++;
                end
            end
            if (due_bytes.size() > first) begin
                res = due_bytes.pop_back();
                res.last_of_run = 1'b1;
                due_bytes.push_back(res);
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_byte(t_result got);
            t_result want;
            if (due_bytes.size() == 0) begin
                $error("result beat with nothing outstanding: channel %0d, byte %02h",
                       got.channel_index, got.data_byte);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            bytes_seen++;
            if (want.framing_flag) framing_seen++;
            if (want.overrun_flag) overrun_seen++;
            check_field("channel_index", want.channel_index, got.channel_index);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("framing_flag", want.framing_flag, got.framing_flag);
            check_field("overrun_flag", want.overrun_flag, got.overrun_flag);
            check_field("ready_bits", want.ready_bits, got.ready_bits);
            check_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [LINES-1:0]     i_line_levels = '1;
    logic [TIME_BITS-1:0] i_now_ticks = '0;
    logic [LINES-1:0]     i_clear_ready_mask = '0;
    logic [LINES-1:0]     i_clear_framing_mask = '0;
    logic [LINES-1:0]     i_clear_overrun_mask = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [CHAN_W-1:0]    o_channel_index;
    logic [7:0]           o_data_byte;
    logic                 o_framing_flag;
    logic                 o_overrun_flag;
    logic [LINES-1:0]     o_ready_bits;
    logic                 o_last_of_run;

    rx_byte_scoreboard    board = new();
    int                   send_idle = 31;
    int                   recv_idle = 87;
    int                   clear_rate = 0;
    int                   phase_items = 0;
    int                   settings_run = 1;
    bit                   hold_req = 1'b0;
    logic [LINES-1:0]     sent_levels = '1;
    logic [TIME_BITS-1:0] stamp = '0;

    edge_timed_uart_receiver i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .push                 (push),
        .full                 (full),
        .i_line_levels        (i_line_levels),
        .i_now_ticks          (i_now_ticks),
        .i_clear_ready_mask   (i_clear_ready_mask),
        .i_clear_framing_mask (i_clear_framing_mask),
        .i_clear_overrun_mask (i_clear_overrun_mask),
        .empty                (empty),
        .pop                  (pop),
        .o_channel_index      (o_channel_index),
        .o_data_byte          (o_data_byte),
        .o_framing_flag       (o_framing_flag),
        .o_overrun_flag       (o_overrun_flag),
        .o_ready_bits         (o_ready_bits),
        .o_last_of_run        (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TIME_BITS-1:0] bit_period();
        return (board.tick_period == '0) ? 32'd1 : {16'd0, board.tick_period};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic offer_sample(input logic [LINES-1:0] lv, input logic [TIME_BITS-1:0] now,
                                input logic [LINES-1:0] cr, input logic [LINES-1:0] cf,
                                input logic [LINES-1:0] co);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_line_levels <= lv;
        i_now_ticks <= now;
        i_clear_ready_mask <= cr;
        i_clear_framing_mask <= cf;
        i_clear_overrun_mask <= co;
        do @(posedge i_clk); while (full);
        board.note_sample(lv, now, cr, cf, co);
        phase_items++;
        sent_levels = lv;
    endtask

    task automatic offer_with_clears(input logic [LINES-1:0] lv, input logic [TIME_BITS-1:0] now);
        logic [LINES-1:0] cr;
        logic [LINES-1:0] cf;
        logic [LINES-1:0] co;
        cr = '0;
        cf = '0;
        co = '0;
        if ($urandom_range(99) < clear_rate) begin
            cr = LINES'($urandom);
            cf = LINES'($urandom);
            co = LINES'($urandom);
        end
        offer_sample(lv, now, cr, cf, co);
    endtask

    // Lay out one frame per active line on a grid of bit periods and send a beat per level change.
    task automatic send_burst(input logic [LINES-1:0] active, input logic [31:0] bytes,
                              input logic [LINES-1:0] stop_low, input logic [7:0] starts,
                              input int unsigned wobble, input int cut);
        logic [15:0]          wave [LINES];
        logic [LINES-1:0]     lv;
        logic [TIME_BITS-1:0] period;
        int                   s;
        period = bit_period();
        for (int ln = 0; ln < LINES; ln++) begin
            wave[ln] = '1;
            if (active[ln]) begin
                s = 1 + starts[2*ln +: 2];
                wave[ln][s] = 1'b0;
                for (int b = 0; b < 8; b++) wave[ln][s+1+b] = bytes[8*ln+b];
                wave[ln][s+9] = !stop_low[ln];
            end
        end
        for (int k = 0; k < cut; k++) begin
            for (int ln = 0; ln < LINES; ln++) lv[ln] = wave[ln][k];
            if (lv != sent_levels) begin
                offer_with_clears(lv, stamp + period * k + $urandom_range(wobble));
            end
        end
        stamp = stamp + period * (15 + $urandom_range(12));
    endtask

    task automatic send_noise();
        logic [TIME_BITS-1:0] period;
        int                   n;
        period = bit_period();
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                offer_with_clears(LINES'($urandom), $urandom);
            end else begin
                offer_with_clears(LINES'($urandom), stamp + $urandom_range(period * 3));
            end
        end
        stamp = stamp + period * 12;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (board.due_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int target);
        logic [LINES-1:0] stop_low;
        logic [TIME_BITS-1:0] period;
        int               pick;
        phase_items = 0;
        while (phase_items < target) begin
            period = bit_period();
            stop_low = '0;
            for (int ln = 0; ln < LINES; ln++) stop_low[ln] = ($urandom_range(9) == 0);
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_noise();
            end else if (pick < 24) begin
                send_burst(LINES'($urandom_range(1, 15)), $urandom, stop_low, 8'($urandom),
                           period, $urandom_range(3, 14));
            end else begin
                send_burst(LINES'($urandom_range(1, 15)), $urandom, stop_low, 8'($urandom),
                           period / 4, 15);
            end
        end
    endtask

    // Result side: random pop idling, one long hold-off on request.
    initial begin
        int      hold_left;
        t_result got;
        hold_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                got.channel_index = o_channel_index;
                got.data_byte = o_data_byte;
                got.framing_flag = o_framing_flag;
                got.overrun_flag = o_overrun_flag;
                got.ready_bits = o_ready_bits;
                got.last_of_run = o_last_of_run;
                board.check_byte(got);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [TPB_W-1:0] ticks;
        logic [TIME_BITS-1:0] period;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: four lines at once, stop low on line 3, then back-to-back frames.
        stamp = 32'hFFFF_FF00;
        period = bit_period();
        send_burst(4'hF, 32'h5AA5_FF00, 4'b1000, 8'hE4, period / 4, 15);
        send_burst(4'hF, 32'h8001_C33C, 4'b0000, 8'h00, period / 4, 15);
        offer_sample(4'h0, 32'hFFFF_FFFF, 4'h0, 4'h0, 4'h0);
        offer_sample(4'hF, 32'h0000_0000, 4'hF, 4'hF, 4'hF);
        drain_results();

        clear_rate = 25;
        for (int p = 0; p < PHASES; p++) begin
            ticks = (p == PHASES - 1) ? TPB_W'($urandom_range(2, 300)) : PHASE_TICKS[p];
            write_reg(REG_LINE_ENABLE, {12'($urandom), PHASE_MASK[p]});
            write_reg(REG_TICKS_PER_BIT, ticks);
            settings_run++;
            send_idle = PHASE_SEND_IDLE[p];
            recv_idle = PHASE_RECV_IDLE[p];
            stamp = $urandom;
            if (p == 0) hold_req = 1'b1;
            run_random(PHASE_ITEMS[p]);
            drain_results();
        end

        if (board.due_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", board.due_bytes.size());
            board.errors++;
        end
        $display("Covered %0d samples and %0d bytes (%0d with framing error, %0d with overrun)",
                 board.samples, board.bytes_seen, board.framing_seen, board.overrun_seen);
        $display("over %0d register settings, enable masks 0 to F, bit periods 0 to 65535.",
                 settings_run);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
